// ===== sv/bsra_pkg.sv =====
// Package: shared constants, payload types and controller/datapath interface types.
`default_nettype none
package bsra_pkg;

  localparam int unsigned PixW     = 15;
  localparam int unsigned PosW     = 16;
  localparam int unsigned SizeW    = 17;
  localparam int unsigned SumW     = 31;
  localparam int unsigned DimW     = 9;
  localparam int unsigned WgtW     = 17;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MemDepth = 65536;
  localparam int unsigned DivCntW  = $clog2(SumW);
  localparam int unsigned ProdW    = 34;

  localparam logic [DimW-1:0] DimMax     = DimW'(256);
  localparam logic [DimW-1:0] DimMin     = DimW'(1);
  localparam logic [WgtW-1:0] WeightOne  = WgtW'(65536);
  localparam logic [WgtW-1:0] WeightRst  = WgtW'(32768);
  localparam logic [PixW-1:0] PixMax     = {PixW{1'b1}};

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [PixW-1:0] pixel;
  } in_req_t;

  typedef struct packed {
    logic [PixW-1:0] difference;
    logic            frame_last;
    logic [PixW-1:0] frame_mean;
  } out_rsp_t;

  typedef struct packed {
    logic take_load;
    logic take_pix;
    logic mul_en;
    logic upd_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) r = DimMin;
    else if (d > DimMax) r = DimMax;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bsra_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bsra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/bsra_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frame mean.
`default_nettype none
module bsra_div
  import bsra_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SumW-1:0]  dividend_i,
  input  wire logic [SizeW-1:0] divisor_i,
  output logic                  done_o,
  output logic      [SumW-1:0]  quot_o
);

  logic [SumW-1:0]    dq_q, dq_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic [SizeW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SizeW:0]     rem_sh;
  logic [SizeW:0]     rem_sub;

  always_comb begin
    rem_sh  = {rem_q, dq_q[SumW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(SumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[SizeW-1:0];
        dq_d  = {dq_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[SizeW-1:0];
        dq_d  = {dq_q[SumW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

// ===== sv/bsra_dp.sv =====
// Datapath: configuration, positions, background store, blend, sum, mean and output register.
`default_nettype none
module bsra_dp
  import bsra_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire in_req_t             in_req_i,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_sts_t                  sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_rsp_t                 out_rsp_o
);

  logic [DimW-1:0]  width_q, height_q;
  logic [WgtW-1:0]  weight_q;
  logic [PosW-1:0]  pix_pos_q, pix_pos_d;
  logic [PosW-1:0]  load_pos_q, load_pos_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PixW-1:0]  pix_q;
  logic [PixW-1:0]  bg_q;
  logic [PixW-1:0]  diff_q;
  logic signed [ProdW-1:0] prod_q;
  logic             last_q;
  logic             out_valid_q;
  out_rsp_t         out_q;

  logic [2*DimW-1:0] size_full;
  logic [SizeW-1:0]  size;
  logic [WgtW-1:0]   w_eff;
  logic [PixW-1:0]   bg_rd;
  logic [PixW-1:0]   ram_rdata_w;
  logic signed [PixW:0]     diff_s;
  logic signed [ProdW-1:0]  prod;
  logic signed [PixW+2:0]   blend;
  logic              pix_last;
  logic              load_last;
  logic              ram_we;
  logic [PosW-1:0]   ram_waddr;
  logic [PixW-1:0]   ram_wdata;
  logic [SumW-1:0]   sum_new;
  logic              div_done;
  logic [SumW-1:0]   quot;
  logic [PixW-1:0]   mean;

  assign size_full = (2*DimW)'(clamp_dim(width_q)) * (2*DimW)'(clamp_dim(height_q));
  assign size      = size_full[SizeW-1:0];
  assign w_eff     = weight_q[WgtW-1] ? WeightOne : weight_q;

  assign pix_last  = ({1'b0, pix_pos_q} + 1'b1) >= size;
  assign load_last = ({1'b0, load_pos_q} + 1'b1) >= size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimMax;
      height_q <= DimMax;
      weight_q <= WeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        CFG_WEIGHT: weight_q <= cfg_data_i[WgtW-1:0];
        default: ;
      endcase
    end
  end

  assign bg_rd  = ram_rdata_w;

  assign ram_we    = cmd_i.take_load || cmd_i.upd_en;
  assign ram_waddr = cmd_i.take_load ? load_pos_q : pix_pos_q;
  assign ram_wdata = cmd_i.take_load ? in_req_i.pixel : blend[PixW-1:0];

  bsra_ram #(
    .Width(PixW),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(pix_pos_q),
    .rdata_o(ram_rdata_w)
  );

  assign diff_s = $signed({1'b0, pix_q}) - $signed({1'b0, bg_rd});
  assign prod   = ProdW'(diff_s) * ProdW'($signed({1'b0, w_eff}));
  assign blend  = $signed({3'b000, bg_q}) + prod_q[ProdW-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pix) begin
      pix_q <= in_req_i.pixel;
    end
    if (cmd_i.mul_en) begin
      bg_q   <= bg_rd;
      prod_q <= prod;
      diff_q <= diff_s[PixW] ? '0 : diff_s[PixW-1:0];
    end
    if (cmd_i.upd_en) begin
      last_q <= pix_last;
    end
  end

  assign sum_new = sum_q + SumW'(pix_q);

  always_comb begin
    pix_pos_d  = pix_pos_q;
    load_pos_d = load_pos_q;
    sum_d      = sum_q;
    if (cmd_i.take_load) begin
      load_pos_d = load_last ? '0 : load_pos_q + 1'b1;
    end
    if (cmd_i.upd_en) begin
      pix_pos_d = pix_last ? '0 : pix_pos_q + 1'b1;
      sum_d     = pix_last ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_pos_q  <= '0;
      load_pos_q <= '0;
      sum_q      <= '0;
    end else begin
      pix_pos_q  <= pix_pos_d;
      load_pos_q <= load_pos_d;
      sum_q      <= sum_d;
    end
  end

  bsra_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.upd_en && pix_last),
    .dividend_i(sum_new),
    .divisor_i (size),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign mean = (quot[SumW-1:PixW] != '0) ? PixMax : quot[PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.difference <= diff_q;
      out_q.frame_last <= last_q;
      out_q.frame_mean <= last_q ? mean : '0;
    end
  end

  assign sts_o.last     = pix_last;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ===== sv/bsra_ctrl.sv =====
// Controller: sequences load, read, blend, update, mean division and result hand-off.
`default_nettype none
module bsra_ctrl
  import bsra_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_cmd_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_UPD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_LOAD) begin
            cmd_o.take_load = 1'b1;
          end else begin
            cmd_o.take_pix = 1'b1;
            state_d        = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_en = 1'b1;
        state_d      = sts_i.last ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== sv/background_subtract_running_average.sv =====
// Top level: running-average background subtraction with per-frame mean.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_req_t  {cmd, pixel}
//   out      output     out_valid_o / out_stall_i out_rsp_t {difference, frame_last, frame_mean}
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A load request is a single write to the background RAM.
// A process request steps through RAM read, blend multiply, write-back and result register.
// The last pixel of a frame adds the bit-serial mean division.
// The result register frees the output side; a waiting result delays the next
// process request only at its hand-off step. Reset clears positions and sum; RAM is not cleared.
`default_nettype none
module background_subtract_running_average
  import bsra_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_req_t             in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_rsp_t                 out_rsp_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bsra_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_cmd_i  (in_req_i.cmd),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bsra_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_req_i.cmd == CMD_LOAD) |=> !in_stall_o)
    else $error("load request did not complete in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.frame_last) |-> (out_rsp_o.frame_mean == '0))
    else $error("mean reported on a pixel that does not end a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_load, cmd.take_pix, cmd.mul_en, cmd.upd_en, cmd.out_load}))
    else $error("controller issued overlapping datapath commands");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the background subtraction block: directed and random requests, built-in predictor.
`default_nettype none
module testbench
  import bsra_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned ONE_WEIGHT    = 65536;
  localparam int unsigned PIX_TOP       = 32767;

  typedef enum int unsigned {PH_GAPPY, PH_STEADY, PH_BACKLOG, PH_PAUSE} phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_req_t             in_req_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_rsp_t            out_rsp_o;

  background_subtract_running_average i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // register shadows, shared by stimulus and predictor (only changed while idle)
  logic [8:0]  reg_width = 9'd256;
  logic [8:0]  reg_height = 9'd256;
  logic [16:0] reg_weight = 17'd32768;

  // predictor state
  logic [PixW-1:0]   bg_frame [MemDepth];
  int unsigned       px_pos = 0;
  int unsigned       ld_pos = 0;
  longint unsigned   px_sum = 0;

  // stimulus-side bookkeeping, so that no unloaded entry is ever read
  bit                bg_written [MemDepth];
  int unsigned       gen_px_pos = 0;
  int unsigned       gen_ld_pos = 0;

  in_req_t           pending_px [$];
  out_rsp_t          expected_rsp [$];

  bit                in_gaps_on = 1'b0;
  bit                out_gaps_on = 1'b0;
  bit                want_hold = 1'b0;
  bit                hold_taken = 1'b0;
  int unsigned       in_gap = 0;
  int unsigned       stall_left = 0;
  int unsigned       hold_left = 0;

  int unsigned       n_cycles = 0;
  int unsigned       n_errors = 0;
  int unsigned       n_loads = 0;
  int unsigned       n_pixels = 0;
  int unsigned       n_frames = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_writes = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned frame_pixels(input logic [8:0] w, input logic [8:0] h);
    int unsigned cw;
    int unsigned ch;
    cw = (w == 0) ? 1 : (w > 256) ? 256 : int'(w);
    ch = (h == 0) ? 1 : (h > 256) ? 256 : int'(h);
    return cw * ch;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    n_errors++;
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [16:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH: begin
        reg_width = value[8:0];
      end
      CFG_HEIGHT: begin
        reg_height = value[8:0];
      end
      default: begin
        reg_weight = value;
      end
    endcase
    n_writes++;
  endtask

  task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input logic [16:0] wt);
    write_reg(CFG_WIDTH, 17'(w));
    write_reg(CFG_HEIGHT, 17'(h));
    write_reg(CFG_WEIGHT, wt);
  endtask

  task automatic queue_item(input in_req_t item);
    int unsigned size;
    size = frame_pixels(reg_width, reg_height);
    if (item.cmd == CMD_LOAD) begin
      bg_written[gen_ld_pos] = 1'b1;
      gen_ld_pos = (gen_ld_pos + 1 >= size) ? 0 : gen_ld_pos + 1;
    end else begin
      gen_px_pos = (gen_px_pos + 1 >= size) ? 0 : gen_px_pos + 1;
    end
    pending_px.push_back(item);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_px.size() != 0 || in_valid_i || expected_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_e kind, input int unsigned n_items);
    logic [8:0]  nw;
    logic [8:0]  nh;
    logic [16:0] nwt;
    in_req_t     item;
    case ($urandom_range(0, 9))
      0: begin
        nw = 9'd0;
        nh = 9'($urandom_range(1, 8));
      end
      1: begin
        nw = 9'd511;
        nh = 9'($urandom_range(0, 1));
      end
      2: begin
        nw = 9'd1;
        nh = 9'd256;
      end
      3: begin
        nw = 9'($urandom_range(9, 40));
        nh = 9'($urandom_range(1, 4));
      end
      default: begin
        nw = 9'($urandom_range(1, 8));
        nh = 9'($urandom_range(1, 8));
      end
    endcase
    if (gen_px_pos >= frame_pixels(nw, nh) && !bg_written[gen_px_pos]) begin
      nw = reg_width;
      nh = reg_height;
    end
    case ($urandom_range(0, 5))
      0: nwt = 17'd0;
      1: nwt = 17'd65536;
      2: nwt = 17'($urandom_range(65537, 131071));
      default: nwt = 17'($urandom_range(0, 65536));
    endcase
    set_frame(nw, nh, nwt);
    in_gaps_on  <= (kind == PH_GAPPY || kind == PH_PAUSE);
    out_gaps_on <= (kind != PH_STEADY);
    if (kind == PH_BACKLOG) want_hold <= 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      item.cmd = ($urandom_range(0, 9) < 7) ? CMD_PROCESS : CMD_LOAD;
      if (item.cmd == CMD_PROCESS && !bg_written[gen_px_pos]) item.cmd = CMD_LOAD;
      case ($urandom_range(0, 7))
        0: item.pixel = '0;
        1: item.pixel = PixMax;
        2: item.pixel = PixW'($urandom_range(0, 63));
        default: item.pixel = PixW'($urandom_range(0, PIX_TOP));
      endcase
      queue_item(item);
      if (kind == PH_PAUSE && i == n_items / 2) wait_idle();
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin : drive_requests
    int unsigned     size;
    int unsigned     bgv;
    int unsigned     wv;
    int unsigned     npx;
    longint unsigned m;
    logic [63:0]     mix;
    out_rsp_t        nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        size = frame_pixels(reg_width, reg_height);
        if (in_req_i.cmd == CMD_LOAD) begin
          bg_frame[ld_pos] = in_req_i.pixel;
          ld_pos = (ld_pos + 1 >= size) ? 0 : ld_pos + 1;
          n_loads++;
        end else begin
          bgv = bg_frame[px_pos];
          wv  = (reg_weight > ONE_WEIGHT) ? ONE_WEIGHT : int'(reg_weight);
          npx = in_req_i.pixel;
          nxt.difference = (npx > bgv) ? PixW'(npx - bgv) : '0;
          mix = 64'(bgv) * 64'(ONE_WEIGHT - wv) + 64'(npx) * 64'(wv);
          bg_frame[px_pos] = mix[30:16];
          px_sum += npx;
          if (px_pos + 1 >= size) begin
            m = px_sum / size;
            nxt.frame_mean = (m > PIX_TOP) ? PixMax : PixW'(m);
            nxt.frame_last = 1'b1;
            px_sum = 0;
            px_pos = 0;
            n_frames++;
          end else begin
            nxt.frame_mean = '0;
            nxt.frame_last = 1'b0;
            px_pos++;
          end
          expected_rsp.push_back(nxt);
          n_pixels++;
        end
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request
      end else if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending_px.size() != 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= pending_px.pop_front();
        in_gap     <= in_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsp.size() == 0) begin
          flag_mismatch("result with no request pending", out_rsp_o.difference, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_o.difference !== want.difference)
            flag_mismatch("difference", out_rsp_o.difference, want.difference);
          if (out_rsp_o.frame_last !== want.frame_last)
            flag_mismatch("frame_last", out_rsp_o.frame_last, want.frame_last);
          if (out_rsp_o.frame_mean !== want.frame_mean)
            flag_mismatch("frame_mean", out_rsp_o.frame_mean, want.frame_mean);
          n_checked++;
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (want_hold && !hold_taken) begin
        hold_taken  <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= pick_gap();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, expected_rsp.size());
      $display("[background_subtract_running_average] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 frame, full weight: background follows the image
    set_frame(9'd2, 9'd2, 17'd65536);
    queue_item('{CMD_LOAD, 15'd0});
    queue_item('{CMD_LOAD, 15'd32767});
    queue_item('{CMD_LOAD, 15'd100});
    queue_item('{CMD_LOAD, 15'd16384});
    queue_item('{CMD_PROCESS, 15'd32767});
    queue_item('{CMD_PROCESS, 15'd0});
    queue_item('{CMD_PROCESS, 15'd100});
    queue_item('{CMD_PROCESS, 15'd32767});
    wait_idle();

    // zero dimensions count as one pixel, zero weight freezes the background
    set_frame(9'd0, 9'd0, 17'd0);
    queue_item('{CMD_PROCESS, 15'd32767});
    queue_item('{CMD_PROCESS, 15'd5});
    wait_idle();

    // oversized width, weight above one
    set_frame(9'd511, 9'd1, 17'd131071);
    repeat (3) queue_item('{CMD_PROCESS, 15'd32767});
    wait_idle();

    // shrink mid-frame: position past the end closes the frame, mean saturates
    set_frame(9'd1, 9'd1, 17'd16384);
    queue_item('{CMD_PROCESS, 15'd32767});
    wait_idle();

    set_frame(9'd256, 9'd0, 17'd40000);
    queue_item('{CMD_LOAD, 15'h5555});
    queue_item('{CMD_LOAD, 15'h2AAA});
    queue_item('{CMD_LOAD, 15'd1234});
    wait_idle();

    // shrink with the load position past the end: load wraps
    set_frame(9'd1, 9'd1, 17'($urandom_range(0, 65536)));
    queue_item('{CMD_LOAD, 15'd777});
    queue_item('{CMD_PROCESS, 15'h2AAA});
    wait_idle();

    run_phase(PH_GAPPY, 48);
    run_phase(PH_STEADY, 48);
    run_phase(PH_BACKLOG, 48);
    run_phase(PH_GAPPY, 48);
    run_phase(PH_PAUSE, 48);
    run_phase(PH_GAPPY, 48);
    run_phase(PH_STEADY, 48);
    run_phase(PH_GAPPY, 48);

    $display("covered %0d background loads and %0d image pixels over %0d register writes",
             n_loads, n_pixels, n_writes);
    $display("%0d frames closed, %0d results checked, %0d mismatches",
             n_frames, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[background_subtract_running_average] OK");
    end else begin
      $display("[background_subtract_running_average] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/bsra_pkg.sv
sv/bsra_ram.sv
sv/bsra_div.sv
sv/bsra_dp.sv
sv/bsra_ctrl.sv
sv/background_subtract_running_average.sv
dv/testbench.sv
